// ----- sv/ais_pkg.sv -----
// Package for the argsort index sorter: entry type, state enum, key compare.
// No dependencies; imported by every module of the block.
`default_nettype none
package ais_pkg;

    localparam int KEY_W = 32;
    localparam int IDX_W = 6;

    typedef struct packed {
        logic                    valid;
        logic signed [KEY_W-1:0] key;
        logic [IDX_W-1:0]        idx;
    } t_entry;

    typedef enum logic {
        ST_FILL,
        ST_DRAIN
    } t_state;

    // True when stored key a must sit after new key b; strict, so ties stay stable.
    function automatic logic goes_after(input logic signed [KEY_W-1:0] a,
                                        input logic signed [KEY_W-1:0] b,
                                        input logic up);
        goes_after = up ? (a > b) : (a < b);
    endfunction

endpackage
`default_nettype wire

// ----- sv/ais_cell.sv -----
// One cell of the insertion chain: holds one key and its arrival index.
// Depends on ais_pkg.
`default_nettype none
module ais_cell
    import ais_pkg::*;
#(
    parameter bit ASCENDING = 1'b1
) (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    input  wire logic   i_ins,
    input  wire logic   i_shift,
    input  wire t_entry i_new,
    input  wire t_entry i_prev,
    input  wire logic   i_prev_after,
    input  wire t_entry i_next,
    output t_entry      o_entry,
    output logic        o_after
);

    logic                    r_valid;
    logic signed [KEY_W-1:0] r_key;
    logic [IDX_W-1:0]        r_idx;
    t_entry                  n_entry;

    assign o_entry = '{valid: r_valid, key: r_key, idx: r_idx};
    // Empty cells count as "after" so the chain fills from the head.
    assign o_after = !r_valid || goes_after(r_key, i_new.key, ASCENDING);

    always_comb begin
        n_entry = o_entry;
        if (i_shift) begin
            n_entry = i_next;
        end else if (i_ins && o_after) begin
            n_entry = i_prev_after ? i_prev : i_new;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_entry.valid;
        end
        r_key <= n_entry.key;
        r_idx <= n_entry.idx;
    end

endmodule
`default_nettype wire

// ----- sv/ais_chain.sv -----
// Row of insertion cells kept sorted in one fixed direction.
// Depends on ais_pkg and ais_cell.
`default_nettype none
module ais_chain
    import ais_pkg::*;
#(
    parameter int MAX_KEYS  = 64,
    parameter bit ASCENDING = 1'b1
) (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    input  wire logic   i_ins,
    input  wire logic   i_shift,
    input  wire t_entry i_new,
    output t_entry      o_head
);

    t_entry w_entry [MAX_KEYS];
    logic   w_after [MAX_KEYS];

    localparam t_entry EMPTY = '{valid: 1'b0, key: '0, idx: '0};

    for (genvar g = 0; g < MAX_KEYS; g++) begin : g_cell
        t_entry w_prev;
        t_entry w_next;
        logic   w_prev_after;

        if (g == 0) begin : g_first
            assign w_prev       = EMPTY;
            assign w_prev_after = 1'b0;
        end else begin : g_mid
            assign w_prev       = w_entry[g-1];
            assign w_prev_after = w_after[g-1];
        end

        if (g == MAX_KEYS - 1) begin : g_last
            assign w_next = EMPTY;
        end else begin : g_inner
            assign w_next = w_entry[g+1];
        end

        ais_cell #(.ASCENDING(ASCENDING)) u_cell (
            .i_clk       (i_clk),
            .i_rst_n     (i_rst_n),
            .i_ins       (i_ins),
            .i_shift     (i_shift),
            .i_new       (i_new),
            .i_prev      (w_prev),
            .i_prev_after(w_prev_after),
            .i_next      (w_next),
            .o_entry     (w_entry[g]),
            .o_after     (w_after[g])
        );
    end

    assign o_head = w_entry[0];

endmodule
`default_nettype wire

// ----- sv/argsort_index_sorter_top.sv -----
// Top level of the argsort index sorter: two insertion chains plus control.
// Depends on ais_pkg and ais_chain.
//
// Usage:
//   Input channel (i_in_valid / o_in_ready): one beat per key, signed Q16.16,
//   its arrival position in the set is its index. The beat with i_last_key
//   high closes the set. Keys are taken one per cycle while filling.
//   Each key is inserted in the same cycle into two chains of MAX_KEYS cells,
//   one kept in ascending and one in descending stable order, so the set is
//   already sorted when it closes.
//   Output channel (o_out_valid / i_out_ready): from the cycle after the
//   closing beat, one index per beat, taken straight from the head cell of
//   the chain chosen by the direction bit sampled on the closing beat. The
//   chain advances by one cell per accepted beat, and a stall simply holds
//   the head. The input is held off (o_in_ready low) while draining, so a
//   new set cannot start until the previous set has drained.
//   Keys arriving once MAX_KEYS are held are dropped and flag o_overflow on
//   every beat of that set's run.
//   Config channel (i_cfg_valid / o_cfg_ready): always ready, bit 0 sets the
//   direction (1 smallest first). Reset: direction ascending, chains empty,
//   block ready for a new set.
`default_nettype none
module argsort_index_sorter_top
    import ais_pkg::*;
#(
    parameter int MAX_KEYS = 64
) (
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    input  wire logic                    i_in_valid,
    output logic                         o_in_ready,
    input  wire logic signed [KEY_W-1:0] i_key_value,
    input  wire logic                    i_last_key,
    output logic                         o_out_valid,
    input  wire logic                    i_out_ready,
    output logic [IDX_W-1:0]             o_sorted_index,
    output logic                         o_last_index,
    output logic                         o_overflow,
    input  wire logic                    i_cfg_valid,
    output logic                         o_cfg_ready,
    input  wire logic                    i_cfg_ascending
);

    localparam int CNT_W = $clog2(MAX_KEYS + 1);

    t_state           r_state, n_state;
    logic [CNT_W-1:0] r_count, n_count;
    logic             r_ovf, n_ovf;
    logic             r_asc;
    logic             r_sel_asc, n_sel_asc;

    logic   w_in_beat, w_out_beat, w_full, w_ins, w_shift;
    t_entry w_new, w_head_up, w_head_dn, w_head;

    assign w_in_beat  = i_in_valid && o_in_ready;
    assign w_out_beat = o_out_valid && i_out_ready;
    assign w_full     = (r_count == CNT_W'(MAX_KEYS));
    assign w_ins      = w_in_beat && !w_full;
    assign w_shift    = w_out_beat;
    assign w_new      = '{valid: 1'b1, key: i_key_value, idx: IDX_W'(r_count)};

    // Direction register; takes a beat at any time, the set samples it on its closing beat.
    assign o_cfg_ready = 1'b1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_asc <= 1'b1;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_asc <= i_cfg_ascending;
        end
    end

    ais_chain #(.MAX_KEYS(MAX_KEYS), .ASCENDING(1'b1)) u_chain_up (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_ins  (w_ins),
        .i_shift(w_shift),
        .i_new  (w_new),
        .o_head (w_head_up)
    );

    ais_chain #(.MAX_KEYS(MAX_KEYS), .ASCENDING(1'b0)) u_chain_dn (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_ins  (w_ins),
        .i_shift(w_shift),
        .i_new  (w_new),
        .o_head (w_head_dn)
    );

    assign w_head = r_sel_asc ? w_head_up : w_head_dn;

    // Next state, count and flags.
    always_comb begin
        n_state   = r_state;
        n_count   = r_count;
        n_ovf     = r_ovf;
        n_sel_asc = r_sel_asc;
        case (r_state)
            ST_FILL: begin
                if (w_in_beat) begin
                    if (w_full) begin
                        n_ovf = 1'b1;
                    end else begin
                        n_count = r_count + CNT_W'(1);
                    end
                    if (i_last_key) begin
                        n_state   = ST_DRAIN;
                        n_sel_asc = r_asc;
                    end
                end
            end
            ST_DRAIN: begin
                if (w_out_beat) begin
                    n_count = r_count - CNT_W'(1);
                    if (r_count == CNT_W'(1)) begin
                        n_state = ST_FILL;
                        n_ovf   = 1'b0;
                    end
                end
            end
            default: begin
                n_state = ST_FILL;
            end
        endcase
    end

    // Handshake outputs from state.
    always_comb begin
        o_in_ready  = 1'b0;
        o_out_valid = 1'b0;
        case (r_state)
            ST_FILL:  o_in_ready  = 1'b1;
            ST_DRAIN: o_out_valid = 1'b1;
            default: begin
                o_in_ready  = 1'b0;
                o_out_valid = 1'b0;
            end
        endcase
    end

    assign o_sorted_index = w_head.idx;
    assign o_last_index   = (r_count == CNT_W'(1));
    assign o_overflow     = r_ovf;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_FILL;
            r_count   <= '0;
            r_ovf     <= 1'b0;
            r_sel_asc <= 1'b1;
        end else begin
            r_state   <= n_state;
            r_count   <= n_count;
            r_ovf     <= n_ovf;
            r_sel_asc <= n_sel_asc;
        end
    end

endmodule
`default_nettype wire

// ----- dv/tb_top.sv -----
`timescale 1ns / 100ps
// Testbench for argsort_index_sorter_top: a table of directed key sets, then random sets,
// every index beat checked against a stable argsort predictor kept in this file.
// Depends on ais_pkg and the block's RTL only.
module tb_top;
    import ais_pkg::*;

    localparam int MAX_KEYS    = 64;
    localparam int QUIET_LIMIT = 2000;
    localparam int ROWS        = 25;
    localparam int RANDOM_KEYS = 260;
    localparam int LONG_HOLD   = 400;

    // One expected beat on the output channel.
    typedef struct packed {
        logic [IDX_W-1:0] idx;
        logic             last;
        logic             ovf;
    } t_rank_beat;

    // One row of the directed table. A row may first rewrite the direction register;
    // a typed row carries its expected index and bypasses the predictor's result.
    typedef struct packed {
        logic signed [KEY_W-1:0] key;
        logic                    last;
        logic                    cfg_wr;
        logic                    cfg_up;
        logic                    typed;
        logic [IDX_W-1:0]        typed_idx;
    } t_key_row;

    logic                    clk = 1'b0;
    logic                    rst_n;
    logic                    in_valid;
    logic                    in_ready;
    logic signed [KEY_W-1:0] key_value;
    logic                    last_key;
    logic                    out_valid;
    logic                    out_ready;
    logic [IDX_W-1:0]        sorted_index;
    logic                    last_index;
    logic                    overflow;
    logic                    cfg_valid;
    logic                    cfg_ready;
    logic                    cfg_asc;

    // Predictor state: keys of the open set, drop flag, direction register copy.
    logic signed [KEY_W-1:0] held_keys [MAX_KEYS];
    int                      held_count;
    logic                    dropped_seen;
    logic                    dir_up;
    t_rank_beat              rank_q [$];
    t_rank_beat              fresh_q [$];

    int   mismatch_count = 0;
    int   quiet_cycles   = 0;
    logic tx_idle_on     = 1'b1;
    logic rand_phase     = 1'b0;

    always #5 clk = ~clk;

    argsort_index_sorter_top #(
        .MAX_KEYS(MAX_KEYS)
    ) u_dut (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_in_valid      (in_valid),
        .o_in_ready      (in_ready),
        .i_key_value     (key_value),
        .i_last_key      (last_key),
        .o_out_valid     (out_valid),
        .i_out_ready     (out_ready),
        .o_sorted_index  (sorted_index),
        .o_last_index    (last_index),
        .o_overflow      (overflow),
        .i_cfg_valid     (cfg_valid),
        .o_cfg_ready     (cfg_ready),
        .i_cfg_ascending (cfg_asc)
    );

    // Absorb one accepted key. On the closing key, rank the held keys by a stable
    // insertion sort and stage one beat per held key in fresh_q, then clear the set.
    task automatic take_key(input logic signed [KEY_W-1:0] key, input logic closing);
        logic [IDX_W-1:0] order [MAX_KEYS];
        int               j;
        t_rank_beat       beat;
        if (held_count < MAX_KEYS) begin
            held_keys[held_count] = key;
            held_count++;
        end else begin
            dropped_seen = 1'b1;
        end
        if (closing) begin
            for (int i = 0; i < held_count; i++) begin
                j = i;
                // strict compare: an equal key never overtakes, so ties keep arrival order
                while (j > 0 && (dir_up ? (held_keys[order[j-1]] > held_keys[i])
                                        : (held_keys[order[j-1]] < held_keys[i]))) begin
                    order[j] = order[j-1];
                    j--;
                end
                order[j] = IDX_W'(i);
            end
            for (int i = 0; i < held_count; i++) begin
                beat.idx  = order[i];
                beat.last = (i == held_count - 1);
                beat.ovf  = dropped_seen;
                fresh_q.insert(fresh_q.size(), beat);
            end
            held_count   = 0;
            dropped_seen = 1'b0;
        end
    endtask

    // Offer one key beat after a random gap; hold it until the block takes it.
    task automatic offer_key(input logic signed [KEY_W-1:0] key, input logic closing,
                             input logic typed, input logic [IDX_W-1:0] typed_idx);
        int         gap;
        t_rank_beat beat;
        gap = tx_idle_on ? $urandom_range(0, 15) : 0;
        @(negedge clk);
        if (gap != 0) begin
            in_valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid  = 1'b1;
        key_value = key;
        last_key  = closing;
        do @(posedge clk); while (!in_ready);
        take_key(key, closing);
        if (typed && closing) begin
            fresh_q.delete();
            beat = '{typed_idx, 1'b1, 1'b0};
            rank_q.insert(rank_q.size(), beat);
        end
        while (fresh_q.size() != 0) rank_q.insert(rank_q.size(), fresh_q.pop_front());
    endtask

    // Rewrite the direction bit once the block has nothing left to emit.
    task automatic write_direction(input logic up);
        @(negedge clk);
        in_valid = 1'b0;
        while (rank_q.size() != 0) @(posedge clk);
        // let the drain of the final beat settle back into filling
        repeat (8) @(posedge clk);
        @(negedge clk);
        cfg_valid = 1'b1;
        cfg_asc   = up;
        do @(posedge clk); while (!cfg_ready);
        dir_up = up;
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    // Mostly full-range keys, with a share of near-zero values to force ties
    // and a share of the field's extremes.
    function automatic logic signed [KEY_W-1:0] random_key();
        case ($urandom_range(0, 7))
            0, 1: random_key = int'($urandom_range(0, 8)) - 4;
            2: begin
                case ($urandom_range(0, 3))
                    0:       random_key = 32'h7FFF_FFFF;
                    1:       random_key = 32'h8000_0000;
                    2:       random_key = 32'h0000_0000;
                    default: random_key = 32'hFFFF_FFFF;
                endcase
            end
            default: random_key = $urandom();
        endcase
    endfunction

    initial begin : stimulus
        t_key_row plan [ROWS];
        int       set_size;
        int       set_no;
        int       keys_sent;

        rst_n        = 1'b0;
        in_valid     = 1'b0;
        key_value    = '0;
        last_key     = 1'b0;
        cfg_valid    = 1'b0;
        cfg_asc      = 1'b1;
        dir_up       = 1'b1;
        held_count   = 0;
        dropped_seen = 1'b0;

        //        key           last  cfg_wr cfg_up typed idx
        plan = '{
            '{32'h0000_0000, 1'b1, 1'b0, 1'b0, 1'b1, 6'd0},  // lone key after reset
            '{32'h7FFF_FFFF, 1'b1, 1'b0, 1'b0, 1'b1, 6'd0},  // lone largest key
            '{32'h8000_0000, 1'b1, 1'b0, 1'b0, 1'b1, 6'd0},  // lone smallest key
            '{32'h8000_0000, 1'b0, 1'b0, 1'b0, 1'b0, 6'd0},  // extremes and signs, ascending
            '{32'h7FFF_FFFF, 1'b0, 1'b0, 1'b0, 1'b0, 6'd0},
            '{32'h0000_0000, 1'b0, 1'b0, 1'b0, 1'b0, 6'd0},
            '{32'hFFFF_FFFF, 1'b0, 1'b0, 1'b0, 1'b0, 6'd0},
            '{32'h0000_0001, 1'b1, 1'b0, 1'b0, 1'b0, 6'd0},
            '{32'h0005_0000, 1'b0, 1'b0, 1'b0, 1'b0, 6'd0},  // equal keys, ascending
            '{32'h0005_0000, 1'b1, 1'b0, 1'b0, 1'b0, 6'd0},
            '{32'h7FFF_FFFF, 1'b0, 1'b1, 1'b0, 1'b0, 6'd0},  // switch to descending
            '{32'h8000_0000, 1'b0, 1'b0, 1'b0, 1'b0, 6'd0},
            '{32'hFFFF_0000, 1'b0, 1'b0, 1'b0, 1'b0, 6'd0},
            '{32'h0001_0000, 1'b1, 1'b0, 1'b0, 1'b0, 6'd0},
            '{32'h0003_0000, 1'b0, 1'b0, 1'b0, 1'b0, 6'd0},  // equal pairs, descending
            '{32'h0007_0000, 1'b0, 1'b0, 1'b0, 1'b0, 6'd0},
            '{32'h0003_0000, 1'b0, 1'b0, 1'b0, 1'b0, 6'd0},
            '{32'h0007_0000, 1'b1, 1'b0, 1'b0, 1'b0, 6'd0},
            '{32'h0000_0001, 1'b0, 1'b0, 1'b0, 1'b0, 6'd0},  // direction flipped mid-set:
            '{32'h0000_0002, 1'b0, 1'b0, 1'b0, 1'b0, 6'd0},  // the whole set sorts ascending
            '{32'h0000_0003, 1'b0, 1'b1, 1'b1, 1'b0, 6'd0},
            '{32'h0000_0004, 1'b1, 1'b0, 1'b0, 1'b0, 6'd0},
            '{32'hAAAA_AAAA, 1'b0, 1'b0, 1'b0, 1'b0, 6'd0},  // alternating bit patterns
            '{32'h5555_5555, 1'b1, 1'b0, 1'b0, 1'b0, 6'd0},
            '{32'h1234_5678, 1'b1, 1'b1, 1'b0, 1'b1, 6'd0}   // lone key, descending
        };

        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        foreach (plan[r]) begin
            if (plan[r].cfg_wr) write_direction(plan[r].cfg_up);
            offer_key(plan[r].key, plan[r].last, plan[r].typed, plan[r].typed_idx);
        end

        // Random sets. Open with a set whose closing key meets a full store and
        // one that fills it exactly; afterwards mostly short sets, a few long ones.
        rand_phase = 1'b1;
        set_no     = 0;
        keys_sent  = 0;
        while (keys_sent < RANDOM_KEYS) begin
            if (set_no == 0)
                set_size = MAX_KEYS + 1;
            else if (set_no == 1)
                set_size = MAX_KEYS;
            else if ($urandom_range(0, 7) == 0)
                set_size = $urandom_range(13, MAX_KEYS + 6);
            else
                set_size = $urandom_range(1, 12);
            if (set_no > 1 && $urandom_range(0, 2) == 0)
                write_direction(1'($urandom_range(0, 1)));
            tx_idle_on = ($urandom_range(0, 3) != 0);
            for (int n = 0; n < set_size; n++)
                offer_key(random_key(), n == set_size - 1, 1'b0, '0);
            keys_sent += set_size;
            set_no++;
        end

        @(negedge clk);
        in_valid = 1'b0;
        while (rank_q.size() != 0) @(posedge clk);
        repeat (20) @(posedge clk);
        if (mismatch_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

    // Receiver: random stall before each beat, with stretches of none. Once, in the
    // middle of a run, hold off for a long stretch so the block stalls its input.
    initial begin : receiver
        int   gap;
        int   beats;
        logic rx_idle_on;
        logic mid_run;
        logic hold_done;
        out_ready  = 1'b0;
        beats      = 0;
        rx_idle_on = 1'b1;
        mid_run    = 1'b0;
        hold_done  = 1'b0;
        @(posedge rst_n);
        forever begin
            if (beats % 32 == 0) rx_idle_on = ($urandom_range(0, 3) != 0);
            gap = rx_idle_on ? $urandom_range(0, 15) : 0;
            if (!hold_done && rand_phase && mid_run) begin
                gap       = LONG_HOLD;
                hold_done = 1'b1;
            end
            @(negedge clk);
            if (gap != 0) begin
                out_ready = 1'b0;
                repeat (gap) @(negedge clk);
            end
            out_ready = 1'b1;
            do @(posedge clk); while (!out_valid);
            mid_run = !last_index;
            beats++;
        end
    end

    // Compare each accepted index beat with the oldest expectation.
    always @(posedge clk) begin : check_beat
        t_rank_beat want;
        if (rst_n && out_valid && out_ready) begin
            if (rank_q.size() == 0) begin
                $display("%0t: index beat expected none actual %0d",
                         $time, sorted_index);
                mismatch_count++;
            end else begin
                want = rank_q.pop_front();
                if (sorted_index !== want.idx) begin
                    $display("%0t: sorted_index expected %0d actual %0d",
                             $time, want.idx, sorted_index);
                    mismatch_count++;
                end
                if (last_index !== want.last) begin
                    $display("%0t: last_index expected %0b actual %0b",
                             $time, want.last, last_index);
                    mismatch_count++;
                end
                if (overflow !== want.ovf) begin
                    $display("%0t: overflow expected %0b actual %0b",
                             $time, want.ovf, overflow);
                    mismatch_count++;
                end
            end
        end
    end

    // Watchdog: end the run once no beat has moved on any channel for too long.
    always @(posedge clk) begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)
            || (cfg_valid && cfg_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles == QUIET_LIMIT) begin
            $display("status: fail");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

endmodule

// ----- filelist.f -----
sv/ais_pkg.sv
sv/ais_cell.sv
sv/ais_chain.sv
sv/argsort_index_sorter_top.sv
dv/tb_top.sv
